@@ hdl/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// condition that forces a consequence in the following cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/bspm_pkg.sv @@
// types and constants of the bracket string pair matcher
package bspm_pkg;

    localparam int MAX_LENGTH  = 1024;
    localparam int POS_W       = 10;
    localparam int POS_CAP     = (1 << POS_W) - 1;
    localparam int POS_LIMIT   = (MAX_LENGTH - 1 < POS_CAP) ? MAX_LENGTH - 1 : POS_CAP;
    localparam int CNT_W       = POS_W + 1;
    localparam int STACK_DEPTH = 1 << POS_W;
    localparam int STACK_AW    = POS_W;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] SYM_OPEN  = 8'h28;
    localparam logic [7:0] SYM_CLOSE = 8'h29;

    localparam logic CMD_CHAR   = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam logic KIND_WRITE   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [1:0] STATUS_OK             = 2'd0;
    localparam logic [1:0] STATUS_UNMATCHED_CLOSE = 2'd1;
    localparam logic [1:0] STATUS_UNMATCHED_OPEN  = 2'd2;
    localparam logic [1:0] STATUS_TOO_LONG        = 2'd3;

    typedef logic [POS_W-1:0] pos_t;

    typedef enum logic [1:0] {
        OP_SINGLE,
        OP_PAIR,
        OP_SUMMARY
    } op_code_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] symbol;
    } in_item_t;

    typedef struct packed {
        logic       kind;
        pos_t       position;
        pos_t       partner;
        logic [1:0] status;
        logic       last;
    } out_item_t;

    // work entry handed from the front to the back
    typedef struct packed {
        op_code_t   code;
        pos_t       position;
        pos_t       partner;
        logic [1:0] status;
    } op_t;

endpackage

@@ hdl/bspm_front.sv @@
// front end: classifies characters, keeps the open-bracket stack and issues work entries
module bspm_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bspm_pkg::in_item_t  s_item,
    output logic                q_valid,
    input  logic                q_ready,
    output bspm_pkg::op_t       q_op
);

    logic [bspm_pkg::CNT_W-1:0] count_reg, count_next;
    logic [bspm_pkg::CNT_W-1:0] next_pos_reg, next_pos_next;
    logic                       close_err_reg, close_err_next;
    logic                       len_err_reg, len_err_next;
    logic                       stage_valid_reg, stage_valid_next;
    bspm_pkg::op_t              stage_op_reg, stage_op_next;

    bspm_pkg::pos_t stack_mem [bspm_pkg::STACK_DEPTH];
    bspm_pkg::pos_t rd_data_reg;
    logic                          stack_we;
    logic                          stack_re;
    logic [bspm_pkg::STACK_AW-1:0] stack_waddr;
    logic [bspm_pkg::STACK_AW-1:0] stack_raddr;

    logic                       accept;
    logic                       too_long;
    logic [bspm_pkg::CNT_W-1:0] count_dec;
    logic [1:0]                 summary_status;

    function automatic bspm_pkg::pos_t count_dec_pos(input logic [bspm_pkg::CNT_W-1:0] p);
        logic [bspm_pkg::CNT_W-1:0] d;
        d = p - 1'b1;
        return d[bspm_pkg::POS_W-1:0];
    endfunction

    assign s_ready   = !stage_valid_reg || q_ready;
    assign accept    = s_valid && s_ready;
    assign too_long  = len_err_reg || (next_pos_reg > bspm_pkg::CNT_W'(bspm_pkg::POS_LIMIT));
    assign count_dec = count_reg - 1'b1;

    assign stack_waddr = count_reg[bspm_pkg::STACK_AW-1:0];
    assign stack_raddr = count_dec[bspm_pkg::STACK_AW-1:0];

    always_comb begin
        if (len_err_reg) begin
            summary_status = bspm_pkg::STATUS_TOO_LONG;
        end else if (close_err_reg) begin
            summary_status = bspm_pkg::STATUS_UNMATCHED_CLOSE;
        end else if (count_reg != '0) begin
            summary_status = bspm_pkg::STATUS_UNMATCHED_OPEN;
        end else begin
            summary_status = bspm_pkg::STATUS_OK;
        end
    end

    always_comb begin
        count_next       = count_reg;
        next_pos_next    = next_pos_reg;
        close_err_next   = close_err_reg;
        len_err_next     = len_err_reg;
        stage_op_next    = stage_op_reg;
        stage_valid_next = stage_valid_reg && !q_ready;
        stack_we         = 1'b0;
        stack_re         = 1'b0;

        if (accept) begin
            stage_op_next.position = next_pos_reg[bspm_pkg::POS_W-1:0];
            stage_op_next.partner  = '0;
            stage_op_next.status   = bspm_pkg::STATUS_OK;
            stage_op_next.code     = bspm_pkg::OP_SINGLE;

            if (s_item.cmd == bspm_pkg::CMD_FINISH) begin
                stage_op_next.code     = bspm_pkg::OP_SUMMARY;
                stage_op_next.position = count_dec_pos(next_pos_reg);
                stage_op_next.status   = summary_status;
                stage_valid_next       = 1'b1;
                count_next             = '0;
                next_pos_next          = bspm_pkg::CNT_W'(1);
                close_err_next         = 1'b0;
                len_err_next           = 1'b0;
            end else if (too_long) begin
                len_err_next = 1'b1;
            end else begin
                next_pos_next = next_pos_reg + 1'b1;
                if (s_item.symbol == bspm_pkg::SYM_OPEN) begin
                    if (count_reg < bspm_pkg::CNT_W'(bspm_pkg::STACK_DEPTH)) begin
                        stack_we   = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end else if (s_item.symbol == bspm_pkg::SYM_CLOSE) begin
                    stage_valid_next = 1'b1;
                    if (count_reg == '0) begin
                        close_err_next = 1'b1;
                    end else begin
                        stack_re           = 1'b1;
                        count_next         = count_dec;
                        stage_op_next.code = bspm_pkg::OP_PAIR;
                    end
                end else begin
                    stage_valid_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stack_we) begin
            stack_mem[stack_waddr] <= next_pos_reg[bspm_pkg::POS_W-1:0];
        end
        if (stack_re) begin
            rd_data_reg <= stack_mem[stack_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg       <= '0;
            next_pos_reg    <= bspm_pkg::CNT_W'(1);
            close_err_reg   <= 1'b0;
            len_err_reg     <= 1'b0;
            stage_valid_reg <= 1'b0;
        end else begin
            count_reg       <= count_next;
            next_pos_reg    <= next_pos_next;
            close_err_reg   <= close_err_next;
            len_err_reg     <= len_err_next;
            stage_valid_reg <= stage_valid_next;
        end
        stage_op_reg <= stage_op_next;
    end

    // opener position comes from the registered stack read, with the staged entry
    always_comb begin
        q_op = stage_op_reg;
        if (stage_op_reg.code == bspm_pkg::OP_PAIR) begin
            q_op.partner = rd_data_reg;
        end
    end

    assign q_valid = stage_valid_reg;

endmodule

@@ hdl/bspm_queue.sv @@
// short work queue between front and back
module bspm_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  bspm_pkg::op_t in_op,
    output logic          out_valid,
    input  logic          out_ready,
    output bspm_pkg::op_t out_op
);

    localparam int AW = $clog2(bspm_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(bspm_pkg::QUEUE_DEPTH + 1);

    bspm_pkg::op_t  entry_reg [bspm_pkg::QUEUE_DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           push;
    logic           pop;

    assign in_ready  = count_reg != CW'(bspm_pkg::QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_op    = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ hdl/bspm_back.sv @@
// back end: turns work entries into result items through an output register
module bspm_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  bspm_pkg::op_t       q_op,
    output logic                m_valid,
    input  logic                m_ready,
    output bspm_pkg::out_item_t m_item
);

    logic                m_valid_reg, m_valid_next;
    bspm_pkg::out_item_t m_item_reg, m_item_next;
    logic                phase_reg, phase_next;
    logic                out_free;
    logic                load;

    assign out_free = !m_valid_reg || m_ready;
    assign load     = out_free && q_valid;
    assign q_ready  = load && ((q_op.code != bspm_pkg::OP_PAIR) || phase_reg);

    always_comb begin
        m_item_next          = m_item_reg;
        m_item_next.kind     = bspm_pkg::KIND_WRITE;
        m_item_next.position = q_op.position;
        m_item_next.partner  = '0;
        m_item_next.status   = bspm_pkg::STATUS_OK;
        m_item_next.last     = 1'b1;
        phase_next           = phase_reg;

        unique case (q_op.code)
            bspm_pkg::OP_SUMMARY: begin
                m_item_next.kind   = bspm_pkg::KIND_SUMMARY;
                m_item_next.status = q_op.status;
            end
            bspm_pkg::OP_PAIR: begin
                // opener entry first, then the closing position
                if (!phase_reg) begin
                    m_item_next.position = q_op.partner;
                    m_item_next.partner  = q_op.position;
                    m_item_next.last     = 1'b0;
                end else begin
                    m_item_next.partner = q_op.partner;
                end
                if (load) begin
                    phase_next = !phase_reg;
                end
            end
            default: begin
                m_item_next.partner = '0;
            end
        endcase

        if (!load) begin
            m_item_next = m_item_reg;
        end

        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            phase_reg   <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            phase_reg   <= phase_next;
        end
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

@@ hdl/bracket_string_pair_matcher_top.sv @@
// Dot-bracket to pair-table converter, top level. One character item is taken
// per cycle when the result side keeps up; an open bracket or a character past
// the length limit gives no result, any other character one pair-table write, a
// close bracket with a partner two writes, and a finish command one summary. The
// result side delivers one item per cycle from its output register while m_ready
// is high, so a run of close brackets, two items each, is bound by that port; a
// four-entry queue between the classifying front and the result back absorbs
// bursts. A close bracket reads its opener from a 1024-entry stack memory with a
// registered read; the result then passes the front stage register, the queue
// and the back output register. Positions run from 1 to 1023; the stack memory
// needs no clearing after reset: only entries written since the last finish are read.
`include "assert_macros.svh"

module bracket_string_pair_matcher_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bspm_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output bspm_pkg::out_item_t m_item
);

    logic          front_valid;
    logic          front_ready;
    bspm_pkg::op_t front_op;
    logic          back_valid;
    logic          back_ready;
    bspm_pkg::op_t back_op;

    logic          pair_first_taken;
    logic          pair_second_ok;
    logic          summary_ok;
    logic          in_stall_ok;

    bspm_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_valid (front_valid),
        .q_ready (front_ready),
        .q_op    (front_op)
    );

    bspm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_op     (front_op),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_op    (back_op)
    );

    bspm_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (back_valid),
        .q_ready (back_ready),
        .q_op    (back_op),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    assign pair_first_taken = m_valid && m_ready && !m_item.last;
    assign pair_second_ok   = m_valid && m_item.last && (m_item.kind == bspm_pkg::KIND_WRITE);
    assign summary_ok       = !(m_valid && (m_item.kind == bspm_pkg::KIND_SUMMARY)) ||
                              ((m_item.partner == '0) && m_item.last);
    assign in_stall_ok      = s_ready || (front_valid && !front_ready);

    `ASSERT_NEXT(a_pair_second, pair_first_taken, pair_second_ok, "pair second item missing")
    `ASSERT_ALWAYS(a_summary_shape, summary_ok, "summary item malformed")
    `ASSERT_ALWAYS(a_stall_only_on_full_queue, in_stall_ok, "input stalled while queue has room")

endmodule
